@@ rtl/core/pps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;
    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int TIME_BITS = 16;
    localparam int ARR_W     = 16;
    localparam int BURST_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int OUT_W     = 16;
    localparam int QDEPTH    = 2;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic                kind;
        logic [ARR_W-1:0]    arrival_time;
        logic [BURST_W-1:0]  burst_length;
        logic [PRIO_W-1:0]   task_priority;
    } t_in;

    typedef struct packed {
        logic [3:0]        slot;
        logic              idle;
        logic              first_run;
        logic [OUT_W-1:0]  response_time;
        logic              finished;
        logic [OUT_W-1:0]  completion_time;
        logic [OUT_W-1:0]  turnaround_time;
        logic [OUT_W-1:0]  waiting_time;
        logic              all_done;
    } t_out;

    // classified command handed from front to back
    typedef struct packed {
        logic                is_tick;
        logic [ARR_W-1:0]    arrival_time;
        logic [BURST_W-1:0]  burst_length;
        logic [PRIO_W-1:0]   task_priority;
    } t_cmd;
endpackage
`default_nettype wire

@@ rtl/core/pps_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface pps_in_if;
    logic          valid;
    logic          ready;
    pps_pkg::t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pps_out_if;
    logic           valid;
    logic           ready;
    pps_pkg::t_out  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pps_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Accept items, drop loads past the table size, queue commands for the back.
module pps_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    pps_in_if.sink               in_ch,
    output pps_pkg::t_cmd        o_cmd,
    output logic                 o_cmd_valid,
    input  wire logic            i_cmd_pop
);
    localparam int PTR_W = $clog2(pps_pkg::QDEPTH);

    pps_pkg::t_cmd r_q [pps_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_fill;
    logic [pps_pkg::CNT_W-1:0] r_loads;
    logic push, keep;

    assign in_ch.ready = (r_fill != PTR_W'(0) + (PTR_W+1)'(pps_pkg::QDEPTH));
    assign push = in_ch.valid && in_ch.ready;
    assign keep = (in_ch.payload.kind == pps_pkg::KIND_TICK) ||
                  (r_loads != pps_pkg::CNT_W'(pps_pkg::SLOTS));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_fill <= '0;
            r_loads <= '0;
        end else begin
            if (push && keep) begin
                r_q[r_wr] <= '{is_tick: in_ch.payload.kind,
                               arrival_time: in_ch.payload.arrival_time,
                               burst_length: in_ch.payload.burst_length,
                               task_priority: in_ch.payload.task_priority};
                r_wr <= r_wr + 1'b1;
                if (in_ch.payload.kind == pps_pkg::KIND_LOAD)
                    r_loads <= r_loads + 1'b1;
            end
            if (i_cmd_pop)
                r_rd <= r_rd + 1'b1;
            r_fill <= r_fill + (PTR_W+1)'(push && keep) - (PTR_W+1)'(i_cmd_pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/pps_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Store tasks; on a tick scan slots one per cycle, then run the winner.
module pps_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  pps_pkg::t_cmd  i_cmd,
    input  wire logic      i_cmd_valid,
    output logic           o_cmd_pop,
    pps_out_if.source      out_ch
);
    localparam int SW = pps_pkg::SLOT_W;
    localparam int CW = pps_pkg::CNT_W;
    localparam int TB = pps_pkg::TIME_BITS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    logic [pps_pkg::ARR_W-1:0]   r_arr   [pps_pkg::SLOTS];
    logic [pps_pkg::BURST_W-1:0] r_burst [pps_pkg::SLOTS];
    logic [pps_pkg::BURST_W-1:0] r_rem   [pps_pkg::SLOTS];
    logic [pps_pkg::PRIO_W-1:0]  r_prio  [pps_pkg::SLOTS];
    logic                        r_start [pps_pkg::SLOTS];
    logic [CW-1:0] r_loaded, r_fin, r_idx;
    logic [TB-1:0] r_time;
    logic          r_have;
    logic [SW-1:0] r_best;
    pps_pkg::t_out r_out;
    pps_pkg::t_out n_out;
    logic          r_ovalid;

    logic [SW-1:0] idx;
    logic          ready_i, better;
    logic [TB-1:0] after;
    logic [TB:0]   tat;
    logic [pps_pkg::BURST_W-1:0] rem_n;

    assign idx = r_idx[SW-1:0];
    assign ready_i = (r_arr[idx] <= r_time) && (r_rem[idx] != '0);
    assign better = !r_have || (r_prio[idx] < r_prio[r_best]) ||
                    ((r_prio[idx] == r_prio[r_best]) && (r_arr[idx] < r_arr[r_best]));
    assign after = (r_time == '1) ? r_time : r_time + 1'b1;
    assign rem_n = r_rem[r_best] - 1'b1;
    assign tat = (TB+1)'(after) - (TB+1)'(r_arr[r_best]);

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid &&
                       (!i_cmd.is_tick || !r_ovalid);
    assign out_ch.valid = r_ovalid;
    assign out_ch.payload = r_out;

    always_comb begin
        n_out = '0;
        if (!r_have) begin
            n_out.idle = 1'b1;
            n_out.all_done = (r_fin >= r_loaded);
        end else begin
            n_out.slot = 4'(r_best);
            if (!r_start[r_best]) begin
                n_out.first_run = 1'b1;
                n_out.response_time = pps_pkg::OUT_W'(r_time - TB'(r_arr[r_best]));
            end
            if (rem_n == '0) begin
                n_out.finished = 1'b1;
                n_out.completion_time = pps_pkg::OUT_W'(after);
                n_out.turnaround_time = pps_pkg::OUT_W'(tat);
                n_out.waiting_time = (tat >= (TB+1)'(r_burst[r_best]))
                    ? pps_pkg::OUT_W'(tat - (TB+1)'(r_burst[r_best])) : '0;
                n_out.all_done = (r_fin + 1'b1 >= r_loaded);
            end else begin
                n_out.all_done = (r_fin >= r_loaded);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_loaded <= '0;
            r_fin <= '0;
            r_time <= '0;
            r_ovalid <= 1'b0;
            r_idx <= '0;
            r_have <= 1'b0;
        end else begin
            if (r_state == ST_OUT)
                r_ovalid <= 1'b1;
            else if (out_ch.ready)
                r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        if (!i_cmd.is_tick) begin
                            r_arr[r_loaded[SW-1:0]]   <= i_cmd.arrival_time;
                            r_burst[r_loaded[SW-1:0]] <= i_cmd.burst_length;
                            r_rem[r_loaded[SW-1:0]]   <= i_cmd.burst_length;
                            r_prio[r_loaded[SW-1:0]]  <= i_cmd.task_priority;
                            r_start[r_loaded[SW-1:0]] <= 1'b0;
                            r_loaded <= r_loaded + 1'b1;
                            if (i_cmd.burst_length == '0)
                                r_fin <= r_fin + 1'b1;
                        end else begin
                            r_idx <= '0;
                            r_have <= 1'b0;
                            r_state <= (r_loaded == '0) ? ST_EXEC : ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (ready_i && better) begin
                        r_best <= idx;
                        r_have <= 1'b1;
                    end
                    if (r_idx + 1'b1 == r_loaded)
                        r_state <= ST_EXEC;
                    r_idx <= r_idx + 1'b1;
                end
                ST_EXEC: begin
                    r_out <= n_out;
                    r_time <= after;
                    if (r_have) begin
                        if (!r_start[r_best])
                            r_start[r_best] <= 1'b1;
                        r_rem[r_best] <= rem_n;
                        if (rem_n == '0)
                            r_fin <= r_fin + 1'b1;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/preemptive_priority_scheduler_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Preemptive priority scheduler over 16 task slots. A tick beat scans the loaded slots,
// one slot compared per cycle by a single shared comparator, then passes through an
// update state (ST_EXEC) and a result state (ST_OUT). A two-entry command queue
// decouples the input from the scan, and the result register lets the next load
// proceed while a result waits.
module preemptive_priority_scheduler_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pps_in_if.sink     in_ch,
    pps_out_if.source  out_ch
);
    pps_pkg::t_cmd cmd;
    logic cmd_valid, cmd_pop;

    pps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop)
    );
    pps_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop), .out_ch(out_ch)
    );

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid) else $error("pop from empty queue");
    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.payload.idle) |->
        (!out_ch.payload.first_run && !out_ch.payload.finished))
        else $error("idle result carries task data");
    a_fin_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.payload.finished) |->
        (out_ch.payload.turnaround_time <= out_ch.payload.completion_time))
        else $error("turnaround exceeds completion");
endmodule
`default_nettype wire
